>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the plane block.
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and disabled while the synchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Two expressions must agree in every cycle.
`define PFP_ASSERT_EQ(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) == (rhs)) \
    else $error("equality check failed");

`endif

>>> hdl/pfp_pkg.sv
// ---------------------------------------------------------------------------
// pfp_pkg
// Widths, latencies and item types of the plane-from-three-points block.
// ---------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

  // Coordinate and intermediate widths.
  localparam int COORD_WIDTH = 24;
  localparam int EDGE_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * EDGE_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int LEN_W       = $clog2(CROSS_W + 1);
  localparam int M_W         = 31;
  localparam int SQ_W        = 2 * M_W;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int UNIT_SHIFT  = 30;
  localparam int NUM_W       = M_W + UNIT_SHIFT + 1;
  localparam int Q_W         = 31;
  localparam int NRM_W       = 32;
  localparam int D_W         = 40;
  localparam int D_SHIFT     = 26;
  localparam int DPROD_W     = COORD_WIDTH + NRM_W;
  localparam int DSUM_W      = DPROD_W + 2;

  // Pipeline latencies of the sub-units in cycles.
  localparam int CROSS_LAT = 4;
  localparam int SCALE_LAT = 4;
  localparam int SQRT_LAT  = ROOT_W + 1;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int OFF_LAT   = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
  } in_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic signed [D_W-1:0]   offset_d;
    logic                    degenerate;
  } out_t;

  // Scaled components with their signs, as they leave the scaling unit.
  typedef struct packed {
    logic [2:0][M_W-1:0] m;
    logic [2:0]          neg;
    logic                degen;
  } scl_t;

endpackage

`default_nettype wire

>>> hdl/plane_from_three_points.sv
// ---------------------------------------------------------------------------
// plane_from_three_points
// Items pass from start to out_strobe through the cross, scale, square root,
// divide and offset sub-units in order; the square root and divider give one
// bit per stage. Throughput: one item per cycle; busy is always low and the
// result strobe cannot be held off. Reset clears only the valid bits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module plane_from_three_points (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire pfp_pkg::in_t    in_item,
  output logic                 out_strobe,
  output pfp_pkg::out_t        out_item
);

  localparam int W      = pfp_pkg::COORD_WIDTH;
  localparam int CW     = pfp_pkg::CROSS_W;
  localparam int SW     = pfp_pkg::SUM_W;
  localparam int RW     = pfp_pkg::ROOT_W;
  localparam int QW     = pfp_pkg::Q_W;
  localparam int NRW    = pfp_pkg::NRM_W;
  localparam int DPW    = pfp_pkg::DPROD_W;
  localparam int DSW    = pfp_pkg::DSUM_W;
  localparam int DW     = pfp_pkg::D_W;
  localparam int INF_N  = pfp_pkg::SQRT_LAT + pfp_pkg::DIV_LAT;
  localparam int P1_N   = pfp_pkg::CROSS_LAT + pfp_pkg::SCALE_LAT + INF_N;

  localparam logic [QW-1:0]         Q_ONE = QW'(1) << pfp_pkg::UNIT_SHIFT;
  localparam logic signed [DSW-1:0] D_RND = DSW'(1) << (pfp_pkg::D_SHIFT - 1);
  localparam logic signed [DSW-1:0] D_HI  = {{(DSW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [DSW-1:0] D_LO  = {{(DSW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic                 cr_valid;
  logic [2:0][CW-1:0]   cr_mag;
  logic [2:0]           cr_neg;
  logic                 sc_valid;
  logic [SW-1:0]        sc_sum;
  pfp_pkg::scl_t        sc_info;
  logic                 sq_valid;
  logic [RW-1:0]        sq_root;
  logic [2:0]           dv_valid;
  logic [QW-1:0]        dv_q [3];

  pfp_pkg::scl_t        inf_r [INF_N];
  logic                 inf_v_r [INF_N];
  logic [2:0][W-1:0]    p1_r [P1_N];

  logic [QW-1:0]           qc [3];
  logic                    v1_r, v2_r;
  logic signed [NRW-1:0]   n1_r [3];
  logic signed [NRW-1:0]   n2_r [3];
  logic [2:0][W-1:0]       p1o_r;
  logic                    dg1_r, dg2_r;
  logic signed [DPW-1:0]   pr_r [3];
  logic signed [DSW-1:0]   t_sum;
  logic signed [DSW-1:0]   u_val;
  logic signed [DSW-1:0]   d_val;
  pfp_pkg::out_t           out_r;
  logic                    out_zero;
  logic                    nx_in_range;

  assign busy = 1'b0;

  // Arithmetic units.
  pfp_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_pts    (in_item),
    .out_valid (cr_valid),
    .out_mag   (cr_mag),
    .out_neg   (cr_neg)
  );

  pfp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cr_valid),
    .in_mag    (cr_mag),
    .in_neg    (cr_neg),
    .out_valid (sc_valid),
    .out_sum   (sc_sum),
    .out_info  (sc_info)
  );

  pfp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_sum    (sc_sum),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  for (genvar j = 0; j < 3; j++) begin : g_div
    pfp_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_valid),
      .in_m      (inf_r[pfp_pkg::SQRT_LAT-1].m[j]),
      .in_root   (sq_root),
      .out_valid (dv_valid[j]),
      .out_q     (dv_q[j])
    );
  end

  // Side lines: first point and component signs wait for the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < INF_N; k++) begin
        inf_v_r[k] <= 1'b0;
      end
    end else begin
      inf_v_r[0] <= sc_valid;
      for (int k = 1; k < INF_N; k++) begin
        inf_v_r[k] <= inf_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    inf_r[0] <= sc_info;
    for (int k = 1; k < INF_N; k++) begin
      inf_r[k] <= inf_r[k-1];
    end
    p1_r[0] <= {in_item.p1_x, in_item.p1_y, in_item.p1_z};
    for (int k = 1; k < P1_N; k++) begin
      p1_r[k] <= p1_r[k-1];
    end
  end

  // Offset stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      v1_r       <= dv_valid[0];
      v2_r       <= v1_r;
      out_strobe <= v2_r;
    end
  end

  // O1: clamp, apply sign, zero the plane for collinear points.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qc[j] = (dv_q[j] > Q_ONE) ? Q_ONE : dv_q[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (inf_r[INF_N-1].degen) begin
        n1_r[j] <= '0;
      end else if (inf_r[INF_N-1].neg[j]) begin
        n1_r[j] <= -NRW'(qc[j]);
      end else begin
        n1_r[j] <= NRW'(qc[j]);
      end
    end
    p1o_r <= p1_r[P1_N-1];
    dg1_r <= inf_r[INF_N-1].degen;
  end

  // O2: products of the first point with the normal.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pr_r[j] <= $signed(p1o_r[2-j]) * n1_r[j];
      n2_r[j] <= n1_r[j];
    end
    dg2_r <= dg1_r;
  end

  // O3: round the dot product, negate and saturate into the result register.
  always_comb begin
    t_sum = DSW'(pr_r[0]) + DSW'(pr_r[1]) + DSW'(pr_r[2]) + D_RND;
    u_val = t_sum >>> pfp_pkg::D_SHIFT;
    d_val = -u_val;
  end

  always_ff @(posedge clk) begin
    out_r.normal_x   <= n2_r[0];
    out_r.normal_y   <= n2_r[1];
    out_r.normal_z   <= n2_r[2];
    out_r.degenerate <= dg2_r;
    if (d_val > D_HI) begin
      out_r.offset_d <= D_HI[DW-1:0];
    end else if (d_val < D_LO) begin
      out_r.offset_d <= D_LO[DW-1:0];
    end else begin
      out_r.offset_d <= d_val[DW-1:0];
    end
  end

  assign out_item = out_r;

  // Terms used by the checks below.
  assign out_zero = (out_item.normal_x == '0) && (out_item.normal_y == '0) &&
                    (out_item.normal_z == '0) && (out_item.offset_d == '0);
  assign nx_in_range = (out_item.normal_x <= 32'sd1073741824) &&
                       (out_item.normal_x >= -32'sd1073741824);

  // Checks on the pipeline alignment and the result.
  `PFP_ASSERT_EQ(a_div_side_align, clk, rst_n, dv_valid[0], inf_v_r[INF_N-1])
  `PFP_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_strobe && out_item.degenerate, out_zero)
  `PFP_ASSERT_IMPL(a_unit_range, clk, rst_n, out_strobe, nx_in_range)

endmodule

`default_nettype wire

>>> hdl/pfp_cross.sv
// ---------------------------------------------------------------------------
// pfp_cross
// Edge vectors, exact cross product and its per-component magnitude and sign.
// ---------------------------------------------------------------------------
`default_nettype none

module pfp_cross (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire pfp_pkg::in_t                          in_pts,
  output logic                                       out_valid,
  output logic [2:0][pfp_pkg::CROSS_W-1:0]           out_mag,
  output logic [2:0]                                 out_neg
);

  localparam int W  = pfp_pkg::COORD_WIDTH;
  localparam int EW = pfp_pkg::EDGE_W;
  localparam int PW = pfp_pkg::PROD_W;
  localparam int CW = pfp_pkg::CROSS_W;

  logic [3:0]              v_r;
  logic signed [EW-1:0]    e1_r [3];
  logic signed [EW-1:0]    e2_r [3];
  logic signed [PW-1:0]    pa_r [3];
  logic signed [PW-1:0]    pb_r [3];
  logic signed [CW-1:0]    cr_r [3];
  logic [2:0][CW-1:0]      mag_r;
  logic [2:0]              neg_r;

  // Valid bits follow the items through the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Stage 1: edges from the first point, one bit wider than a coordinate.
  always_ff @(posedge clk) begin
    e1_r[0] <= {in_pts.p2_x[W-1], in_pts.p2_x} - {in_pts.p1_x[W-1], in_pts.p1_x};
    e1_r[1] <= {in_pts.p2_y[W-1], in_pts.p2_y} - {in_pts.p1_y[W-1], in_pts.p1_y};
    e1_r[2] <= {in_pts.p2_z[W-1], in_pts.p2_z} - {in_pts.p1_z[W-1], in_pts.p1_z};
    e2_r[0] <= {in_pts.p3_x[W-1], in_pts.p3_x} - {in_pts.p1_x[W-1], in_pts.p1_x};
    e2_r[1] <= {in_pts.p3_y[W-1], in_pts.p3_y} - {in_pts.p1_y[W-1], in_pts.p1_y};
    e2_r[2] <= {in_pts.p3_z[W-1], in_pts.p3_z} - {in_pts.p1_z[W-1], in_pts.p1_z};
  end

  // Stage 2: the six partial products of the cross product.
  always_ff @(posedge clk) begin
    pa_r[0] <= e1_r[1] * e2_r[2];
    pb_r[0] <= e1_r[2] * e2_r[1];
    pa_r[1] <= e1_r[2] * e2_r[0];
    pb_r[1] <= e1_r[0] * e2_r[2];
    pa_r[2] <= e1_r[0] * e2_r[1];
    pb_r[2] <= e1_r[1] * e2_r[0];
  end

  // Stage 3: exact cross product components.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      cr_r[j] <= CW'(pa_r[j]) - CW'(pb_r[j]);
    end
  end

  // Stage 4: sign and magnitude of each component.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      neg_r[j] <= cr_r[j][CW-1];
      mag_r[j] <= cr_r[j][CW-1] ? CW'(-cr_r[j]) : CW'(cr_r[j]);
    end
  end

  assign out_valid = v_r[3];
  assign out_mag   = mag_r;
  assign out_neg   = neg_r;

endmodule

`default_nettype wire

>>> hdl/pfp_scale.sv
// ---------------------------------------------------------------------------
// pfp_scale
// Common block shift of the cross product to 31 bits and its squared norm.
// ---------------------------------------------------------------------------
`default_nettype none

module pfp_scale (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic [2:0][pfp_pkg::CROSS_W-1:0]      in_mag,
  input  wire logic [2:0]                            in_neg,
  output logic                                       out_valid,
  output logic [pfp_pkg::SUM_W-1:0]                  out_sum,
  output pfp_pkg::scl_t                              out_info
);

  localparam int CW    = pfp_pkg::CROSS_W;
  localparam int LW    = pfp_pkg::LEN_W;
  localparam int MW    = pfp_pkg::M_W;
  localparam int SQW   = pfp_pkg::SQ_W;
  localparam int SW    = pfp_pkg::SUM_W;
  localparam int EXT_W = CW + MW;

  logic [3:0]          v_r;
  logic [CW-1:0]       orv;
  logic [LW-1:0]       len_nxt;
  logic [LW-1:0]       len_r;
  logic [2:0][CW-1:0]  mag_r;
  logic [2:0]          neg_a_r;
  logic [EXT_W-1:0]    shf [3];
  pfp_pkg::scl_t       inf_b_r;
  pfp_pkg::scl_t       inf_c_r;
  pfp_pkg::scl_t       inf_d_r;
  logic [SQW-1:0]      sq_r [3];
  logic [SW-1:0]       sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Stage A: bit length of the largest magnitude.
  always_comb begin
    orv     = in_mag[0] | in_mag[1] | in_mag[2];
    len_nxt = '0;
    for (int i = 0; i < CW; i++) begin
      if (orv[i]) begin
        len_nxt = LW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    mag_r   <= in_mag;
    neg_a_r <= in_neg;
  end

  // Stage B: shift all three so the largest lands in [2^30, 2^31).
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (len_r > LW'(MW)) begin
        shf[j] = EXT_W'(mag_r[j]) >> (len_r - LW'(MW));
      end else begin
        shf[j] = EXT_W'(mag_r[j]) << (LW'(MW) - len_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      inf_b_r.m[j] <= shf[j][MW-1:0];
    end
    inf_b_r.neg   <= neg_a_r;
    inf_b_r.degen <= (len_r == '0);
  end

  // Stage C: squares of the scaled components.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq_r[j] <= inf_b_r.m[j] * inf_b_r.m[j];
    end
    inf_c_r <= inf_b_r;
  end

  // Stage D: squared norm.
  always_ff @(posedge clk) begin
    sum_r   <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    inf_d_r <= inf_c_r;
  end

  assign out_valid = v_r[3];
  assign out_sum   = sum_r;
  assign out_info  = inf_d_r;

endmodule

`default_nettype wire

>>> hdl/pfp_sqrt.sv
// ---------------------------------------------------------------------------
// pfp_sqrt
// Pipelined digit-by-digit square root, one result bit per stage, with a
// final stage that rounds to the nearest integer.
// ---------------------------------------------------------------------------
`default_nettype none

module pfp_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [pfp_pkg::SUM_W-1:0]     in_sum,
  output logic                               out_valid,
  output logic [pfp_pkg::ROOT_W-1:0]         out_root
);

  localparam int SW  = pfp_pkg::SUM_W;
  localparam int RW  = pfp_pkg::ROOT_W;
  localparam int XW  = RW + 2;

  logic          v_r    [RW];
  logic [XW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] s_r    [RW];
  logic          vo_r;
  logic [RW-1:0] ro_r;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic          v_in;
    logic [XW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] s_in;
    logic [XW-1:0] x;
    logic [XW-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = in_sum;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign s_in    = s_r[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign x     = {rem_in[XW-3:0], s_in[SW-1-2*k -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      s_r[k] <= s_in;
      if (x >= trial) begin
        rem_r[k]  <= x - trial;
        root_r[k] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_r[k]  <= x;
        root_r[k] <= {root_in[RW-2:0], 1'b0};
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rem_r[RW-1] > XW'(root_r[RW-1])) begin
      ro_r <= root_r[RW-1] + RW'(1);
    end else begin
      ro_r <= root_r[RW-1];
    end
  end

  assign out_valid = vo_r;
  assign out_root  = ro_r;

endmodule

`default_nettype wire

>>> hdl/pfp_div.sv
// ---------------------------------------------------------------------------
// pfp_div
// Pipelined restoring divider for one normal component: rounded quotient of
// the scaled component times 2^30 by the root, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module pfp_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [pfp_pkg::M_W-1:0]       in_m,
  input  wire logic [pfp_pkg::ROOT_W-1:0]    in_root,
  output logic                               out_valid,
  output logic [pfp_pkg::Q_W-1:0]            out_q
);

  localparam int RW  = pfp_pkg::ROOT_W;
  localparam int QW  = pfp_pkg::Q_W;
  localparam int NW  = pfp_pkg::NUM_W;
  localparam int XW  = RW + 1;
  localparam int UNS = pfp_pkg::UNIT_SHIFT;

  logic [NW-1:0] num;
  logic          v_r   [QW+1];
  logic [XW-1:0] rem_r [QW+1];
  logic [QW-1:0] low_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [RW-1:0] d_r   [QW+1];

  // Numerator with half the divisor added for rounding to nearest.
  assign num = (NW'(in_m) << UNS) + NW'(in_root >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  // Load: the upper numerator bits are already below the divisor.
  always_ff @(posedge clk) begin
    rem_r[0] <= XW'(num[NW-1:QW]);
    low_r[0] <= num[QW-1:0];
    q_r[0]   <= '0;
    d_r[0]   <= in_root;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [XW-1:0] x;

    assign x = {rem_r[i-1][RW-1:0], low_r[i-1][QW-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      low_r[i] <= {low_r[i-1][QW-2:0], 1'b0};
      d_r[i]   <= d_r[i-1];
      if (x >= XW'(d_r[i-1])) begin
        rem_r[i] <= x - XW'(d_r[i-1]);
        q_r[i]   <= {q_r[i-1][QW-2:0], 1'b1};
      end else begin
        rem_r[i] <= x;
        q_r[i]   <= {q_r[i-1][QW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_q     = q_r[QW];

endmodule

`default_nettype wire

>>> tb/plane_checker.sv
// ---------------------------------------------------------------------------
// plane_checker
// Watches the item and result channels of the plane block, predicts each
// plane from its three points and compares every result field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module plane_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire pfp_pkg::in_t  in_item,
  input  wire logic          out_strobe,
  input  wire pfp_pkg::out_t out_item,
  output int                 err_count,
  output int                 planes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  pfp_pkg::out_t planes_due[$];

  // Integer square root rounded to nearest.
  function automatic logic [63:0] root_nearest(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] cand;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= s) res = cand;
    end
    if (s - res * res > res) res = res + 1;
    return res;
  endfunction

  // Plane through three points: unit normal in Q1.30 and offset in Q35.4.
  function automatic pfp_pkg::out_t plane_of(pfp_pkg::in_t pt);
    pfp_pkg::out_t pl;
    longint      p1[3], p2[3], p3[3], e1[3], e2[3], cr[3], nrm[3];
    logic [63:0] mag[3], m[3], all_bits, s, r, q;
    int          len;
    longint      t, u, d;
    p1[0] = pt.p1_x; p1[1] = pt.p1_y; p1[2] = pt.p1_z;
    p2[0] = pt.p2_x; p2[1] = pt.p2_y; p2[2] = pt.p2_z;
    p3[0] = pt.p3_x; p3[1] = pt.p3_y; p3[2] = pt.p3_z;
    for (int j = 0; j < 3; j++) begin
      e1[j] = p2[j] - p1[j];
      e2[j] = p3[j] - p1[j];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    all_bits = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = (cr[j] < 0) ? -cr[j] : cr[j];
      all_bits |= mag[j];
    end
    pl = '0;
    // Collinear points give the zero plane.
    if (all_bits == 0) begin
      pl.degenerate = 1'b1;
      return pl;
    end
    len = 0;
    for (int b = 0; b < 64; b++) if (all_bits[b]) len = b + 1;
    // Bring the largest magnitude into [2^30, 2^31).
    for (int j = 0; j < 3; j++)
      m[j] = (len > 31) ? (mag[j] >> (len - 31)) : (mag[j] << (31 - len));
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = root_nearest(s);
    t = 0;
    for (int j = 0; j < 3; j++) begin
      q = ((m[j] << pfp_pkg::UNIT_SHIFT) + (r >> 1)) / r;
      if (q > (64'd1 << pfp_pkg::UNIT_SHIFT)) q = 64'd1 << pfp_pkg::UNIT_SHIFT;
      nrm[j] = (cr[j] < 0) ? -longint'(q) : longint'(q);
      t += p1[j] * nrm[j];
    end
    // Round the dot product to nearest, ties toward plus infinity.
    u = (t + (longint'(1) << (pfp_pkg::D_SHIFT - 1))) >>> pfp_pkg::D_SHIFT;
    d = -u;
    if (d > 64'sd549755813887) d = 64'sd549755813887;
    if (d < -64'sd549755813888) d = -64'sd549755813888;
    pl.normal_x = nrm[0][pfp_pkg::NRM_W-1:0];
    pl.normal_y = nrm[1][pfp_pkg::NRM_W-1:0];
    pl.normal_z = nrm[2][pfp_pkg::NRM_W-1:0];
    pl.offset_d = d[pfp_pkg::D_W-1:0];
    return pl;
  endfunction

  assign planes_pending = planes_due.size();

  // Record accepted items and compare results against the oldest plane due.
  always @(posedge clk) begin
    pfp_pkg::out_t exp_pl;
    if (!rst_n) begin
      err_count <= 0;
    end else begin
      if (out_strobe) begin
        if (planes_due.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_item);
          err_count <= err_count + 1;
        end else begin
          exp_pl = planes_due.pop_front();
          if (exp_pl !== out_item) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_pl, out_item);
            err_count <= err_count + 1;
          end
        end
      end
      if (start && !busy) planes_due.push_back(plane_of(in_item));
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_plane_from_three_points.sv
// ---------------------------------------------------------------------------
// tb_plane_from_three_points
// Drives directed and random point triples into the plane block with random
// gaps; the checker beside it predicts and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_plane_from_three_points;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  pfp_pkg::in_t  in_item = '0;
  logic          out_strobe;
  pfp_pkg::out_t out_item;
  int            err_count;
  int            planes_pending;
  bit            no_gaps = 1'b0;

  localparam pfp_pkg::coord_t C_MAX = 24'sh7FFFFF;
  localparam pfp_pkg::coord_t C_MIN = 24'sh800000;

  plane_from_three_points u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  plane_checker u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .err_count(err_count), .planes_pending(planes_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one triple and hold it until the block takes it.
  task automatic send_triple(pfp_pkg::in_t v);
    if (!no_gaps && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_item <= v;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  function automatic pfp_pkg::coord_t rand_coord(int span);
    if (span >= 24) return pfp_pkg::coord_t'($urandom);
    return pfp_pkg::coord_t'($urandom_range(0, (1 << span) - 1) - (1 << (span - 1)));
  endfunction

  function automatic pfp_pkg::in_t from_points(pfp_pkg::coord_t a[3],
                                               pfp_pkg::coord_t b[3],
                                               pfp_pkg::coord_t c[3]);
    pfp_pkg::in_t v;
    v.p1_x = a[0]; v.p1_y = a[1]; v.p1_z = a[2];
    v.p2_x = b[0]; v.p2_y = b[1]; v.p2_z = b[2];
    v.p3_x = c[0]; v.p3_y = c[1]; v.p3_z = c[2];
    return v;
  endfunction

  // Random triple: full range, small, collinear or with a repeated point.
  function automatic pfp_pkg::in_t random_triple();
    pfp_pkg::coord_t a[3], b[3], c[3];
    int              span, k, kind;
    kind = $urandom_range(99);
    span = ($urandom_range(1) == 1) ? 24 : $urandom_range(2, 23);
    for (int j = 0; j < 3; j++) begin
      a[j] = rand_coord(span);
      b[j] = rand_coord(span);
      c[j] = rand_coord(span);
    end
    if (kind < 10) begin
      // Third point on the line through the first two.
      k = $urandom_range(0, 6) - 3;
      for (int j = 0; j < 3; j++) begin
        a[j] = rand_coord(12);
        b[j] = a[j] + rand_coord(8);
        c[j] = a[j] + k * (b[j] - a[j]);
      end
    end else if (kind < 15) begin
      if ($urandom_range(1) == 1) begin
        c = a;
      end else begin
        c = b;
      end
    end
    return from_points(a, b, c);
  endfunction

  initial begin
    pfp_pkg::coord_t z[3], hi[3], lo[3], ex[3], ey[3], ez[3], one[3];
    int              waited;
    z = '{0, 0, 0};
    hi = '{C_MAX, C_MAX, C_MAX};
    lo = '{C_MIN, C_MIN, C_MIN};
    ex = '{24'sd4096, 0, 0};
    ey = '{0, 24'sd4096, 0};
    ez = '{0, 0, 24'sd4096};
    one = '{24'sd4096, 24'sd4096, 24'sd4096};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed triples: degenerate cases, axis planes, extremes of the range.
    send_triple(from_points(z, z, z));
    send_triple(from_points(hi, hi, hi));
    send_triple(from_points(z, one, '{24'sd8192, 24'sd8192, 24'sd8192}));
    send_triple(from_points(z, ex, ey));
    send_triple(from_points(z, ey, ex));
    send_triple(from_points(z, ey, ez));
    send_triple(from_points(z, ez, ex));
    send_triple(from_points(one, ex, ey));
    send_triple(from_points(ex, ey, ez));
    send_triple(from_points(lo, '{C_MAX, C_MIN, C_MIN}, '{C_MIN, C_MAX, C_MIN}));
    send_triple(from_points(hi, '{C_MIN, C_MAX, C_MAX}, '{C_MAX, C_MIN, C_MAX}));
    send_triple(from_points('{C_MAX, C_MIN, C_MAX}, '{C_MIN, C_MAX, C_MIN},
                            '{C_MIN, C_MIN, C_MAX}));
    send_triple(from_points(z, '{24'sd1, 0, 0}, '{0, 24'sd1, 0}));
    send_triple(from_points(hi, '{C_MAX - 1, C_MAX, C_MAX}, '{C_MAX, C_MAX - 1, C_MAX}));
    send_triple(from_points(z, '{24'sd1, 24'sd1, 0}, '{0, 0, 24'sd1}));
    send_triple(from_points(lo, hi, z));
    send_triple(from_points(lo, z, hi));

    // Random triples, with a burst run back to back.
    for (int n = 0; n < 650; n++) begin
      no_gaps = (n >= 200 && n < 320);
      if (n == 400) begin
        start <= 1'b0;
        waited = 0;
        while (planes_pending != 0 && waited < 2000) begin
          @(posedge clk);
          waited++;
        end
      end
      send_triple(random_triple());
    end
    start <= 1'b0;

    waited = 0;
    while (planes_pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (err_count == 0 && planes_pending == 0) begin
      $display("tb_plane_from_three_points: done, clean");
    end else begin
      $display("tb_plane_from_three_points: done, errors");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #200us;
    $display("tb_plane_from_three_points: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/pfp_pkg.sv
hdl/pfp_cross.sv
hdl/pfp_scale.sv
hdl/pfp_sqrt.sv
hdl/pfp_div.sv
hdl/plane_from_three_points.sv
tb/plane_checker.sv
tb/tb_plane_from_three_points.sv
